// File: hw/rtl/smf_pkg.sv
`timescale 1ns / 1ps

package smf_pkg;

  // Default sizes of the sample store and of one sample.
  localparam int unsigned MaxWindowDef  = 32;
  localparam int unsigned SampleBitsDef = 16;

  // The two selectable window lengths.
  localparam int unsigned SmallWindow = 16;
  localparam int unsigned LargeWindow = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_DONE
  } state_e;

  // Controls for the insertion sorter.
  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctrl_t;

endpackage

// File: hw/rtl/smf_ram.sv
`timescale 1ns / 1ps

module smf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/smf_sorter.sv
`timescale 1ns / 1ps

module smf_sorter
  import smf_pkg::*;
#(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sort_ctrl_t                           ctrl_i,
  input  logic signed [SampleBits-1:0]         data_i,
  input  logic        [$clog2(MaxWindow)-1:0]  rank_i,
  output logic signed [SampleBits-1:0]         rank_data_o,
  output logic        [MaxWindow-1:0]          used_o
);

  logic signed [SampleBits-1:0] cell_q [MaxWindow];
  logic signed [SampleBits-1:0] cell_d [MaxWindow];
  logic [MaxWindow-1:0]         used_q, used_d, gt;

  // Each cell compares itself with the incoming value; the cells above the
  // insertion point shift up by one, all in the same cycle.
  for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
    assign gt[k] = used_q[k] && (cell_q[k] > data_i);

    if (k == 0) begin : g_first
      always_comb begin
        cell_d[k] = cell_q[k];
        used_d[k] = used_q[k];
        if (ctrl_i.clear) begin
          used_d[k] = 1'b0;
        end else if (ctrl_i.insert) begin
          if (gt[k] || !used_q[k]) begin
            cell_d[k] = data_i;
          end
          used_d[k] = 1'b1;
        end
      end
    end else begin : g_rest
      always_comb begin
        cell_d[k] = cell_q[k];
        used_d[k] = used_q[k];
        if (ctrl_i.clear) begin
          used_d[k] = 1'b0;
        end else if (ctrl_i.insert) begin
          if (gt[k-1]) begin
            cell_d[k] = cell_q[k-1];
          end else if (gt[k] || !used_q[k]) begin
            cell_d[k] = data_i;
          end
          used_d[k] = used_q[k] | used_q[k-1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      cell_q[k] <= cell_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign rank_data_o = cell_q[rank_i];
  assign used_o      = used_q;

endmodule

// File: hw/rtl/sliding_median_filter_top.sv
`timescale 1ns / 1ps

// Sliding-window median filter. Signed samples arrive one beat at a time and
// are written into a circular sample memory; once the current record holds at
// least W samples (W is 16 or 32, chosen by the window_is_32 register and
// capped at MaxWindow), each new sample yields one result beat carrying the
// upper median, the element at ascending rank W/2 of the last W samples. A
// beat with block_start set begins a new record and restarts the fill count.
// A sample that produces a result occupies the block while it is accepted and
// stored, while the memory read port delivers the window one sample per cycle
// into an insertion sorter, while the last word comes out of the read port,
// while the control moves on to completion, and while the output register is
// loaded, which waits until any earlier result has been taken. A sample that
// produces no result leaves the block idle. A finished result waits in the
// output register, and the next sample is accepted while it waits. The sample
// memory needs no clearing after reset. The window register may only be
// written while the block is idle.

module sliding_median_filter_top
  import smf_pkg::*;
#(
  parameter int unsigned MaxWindow  = MaxWindowDef,
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // Window length register write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_window_is_32_i,

  // Sample input channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic                         block_start_i,

  // Median output channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SampleBits-1:0] median_o
);

  localparam int unsigned PtrW = $clog2(MaxWindow);
  localparam int unsigned CntW = $clog2(MaxWindow + 1);

  // Window lengths after capping at the store depth.
  localparam int unsigned WinSmall = (SmallWindow > MaxWindow) ? MaxWindow : SmallWindow;
  localparam int unsigned WinLarge = (LargeWindow > MaxWindow) ? MaxWindow : LargeWindow;

  state_e                       state_q, state_d;
  logic [CntW-1:0]              fill_q, fill_d;
  logic [PtrW-1:0]              wp_q, wp_d;
  logic [PtrW-1:0]              rp_q, rp_d;
  logic [CntW-1:0]              iss_q, iss_d;
  logic [CntW-1:0]              win_q, win_d;
  logic                         ins_q, ins_d;
  logic                         w32_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] median_q, median_d;

  logic                         in_fire;
  logic [CntW-1:0]              fill_base, fill_new, win_sel;
  logic [PtrW-1:0]              wp_inc, rp_dec;
  logic                         ram_we;
  logic [SampleBits-1:0]        ram_rdata;
  sort_ctrl_t                   sort_ctrl;
  logic signed [SampleBits-1:0] rank_data;
  logic [MaxWindow-1:0]         sort_used;

  // The register port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w32_q <= 1'b0;
    end else if (cfg_valid_i) begin
      w32_q <= cfg_window_is_32_i;
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  // A block start restarts the count before the flagged sample is counted.
  // The count saturates at the store depth.
  assign fill_base = block_start_i ? '0 : fill_q;
  assign fill_new  = (fill_base < CntW'(MaxWindow)) ? fill_base + 1'b1 : fill_base;
  assign win_sel   = w32_q ? CntW'(WinLarge) : CntW'(WinSmall);

  // Pointers wrap at the store depth, which need not be a power of two.
  assign wp_inc = (wp_q == PtrW'(MaxWindow - 1)) ? '0 : wp_q + 1'b1;
  assign rp_dec = (rp_q == '0) ? PtrW'(MaxWindow - 1) : rp_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      wp_q        <= '0;
      rp_q        <= '0;
      iss_q       <= '0;
      win_q       <= '0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      iss_q       <= iss_d;
      win_q       <= win_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    median_q <= median_d;
  end

  // The sample is written at the accepting edge and the window is read back
  // only from the next cycle on, so a read never meets a write to the same
  // entry.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    iss_d       = iss_q;
    win_d       = win_q;
    ins_d       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    median_d    = median_q;
    in_ready_o  = 1'b0;
    ram_we      = 1'b0;
    sort_ctrl   = '{clear: 1'b0, insert: ins_q};

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          ram_we          = 1'b1;
          sort_ctrl.clear = 1'b1;
          fill_d          = fill_new;
          wp_d            = wp_inc;
          rp_d            = wp_q;
          iss_d           = '0;
          win_d           = win_sel;
          if (fill_new >= win_sel) begin
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        // Walk back from the newest sample, one read per cycle; each read
        // word is inserted into the sorter in the following cycle.
        if (iss_q != win_q) begin
          rp_d  = rp_dec;
          iss_d = iss_q + 1'b1;
          ins_d = 1'b1;
        end else if (!ins_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          median_d    = rank_data;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  smf_ram #(
    .Width (SampleBits),
    .Depth (MaxWindow)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  smf_sorter #(
    .MaxWindow  (MaxWindow),
    .SampleBits (SampleBits)
  ) u_sorter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (sort_ctrl),
    .data_i      (ram_rdata),
    .rank_i      (PtrW'(win_q >> 1)),
    .rank_data_o (rank_data),
    .used_o      (sort_used)
  );

  assign out_valid_o = out_valid_q;
  assign median_o    = median_q;

`ifndef SYNTH
  // Sorter inserts only happen while the window is being read back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_q |-> state_q == ST_SORT)
    else $error("sorter insert outside of the read-back phase");

  // When the median is taken, the sorter holds exactly one window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |-> $countones(sort_used) == int'(win_q))
    else $error("sorter occupancy differs from the window length");

  // A new result only ever comes from the completion state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside of the completion state");
`endif

endmodule
